FILE: rtl/core/skf_pkg.sv
`timescale 1ns / 1ps

package skf_pkg;

   // Time step is always an unsigned Q0.16 fraction
   localparam int TS_BITS = 16;
   localparam logic [TS_BITS-1:0] TS_RESET = 16'd6554;  // 0.1

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_PROCESS_NOISE     = 2'd0,
      CSR_MEASUREMENT_NOISE = 2'd1,
      CSR_VELOCITY          = 2'd2,
      CSR_TIME_STEP         = 2'd3
   } csr_index_type;

   // Operand pairs of the shared multiplier
   typedef enum logic [1:0] {
      MUL_DRIFT = 2'd0,   // velocity * time_step
      MUL_CORR  = 2'd1,   // innovation * gain
      MUL_VAR   = 2'd2    // predicted variance * (1 - gain)
   } mul_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'd0,
      ST_DRIFT   = 3'd1,
      ST_PREDICT = 3'd2,
      ST_DIVIDE  = 3'd3,
      ST_CORR    = 3'd4,
      ST_VAR     = 3'd5,
      ST_UPDATE  = 3'd6,
      ST_DONE    = 3'd7
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic        capture;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        load_pred;
      logic        div_step;
      logic        div_first;
      logic        upd_estimate;
      logic        upd_variance;
      logic        rsp_load;
   } cmd_type;

endpackage

FILE: rtl/core/skf_ctrl.sv
`timescale 1ns / 1ps

module skf_ctrl #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output skf_pkg::cmd_type  cmd
);

   // One quotient bit per step, integer bit included
   localparam int DIV_STEPS = FRAC_BITS + 1;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   skf_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skf_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Sequencer: next state and datapath commands
   always_comb begin
      state_in         = state_ff;
      cnt_in           = cnt_ff;
      req_ready        = 1'b0;
      cmd              = '0;
      cmd.mul_sel      = skf_pkg::MUL_DRIFT;
      unique case (state_ff)
         skf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = skf_pkg::ST_DRIFT;
            end
         end
         skf_pkg::ST_DRIFT: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = skf_pkg::MUL_DRIFT;
            state_in    = skf_pkg::ST_PREDICT;
         end
         skf_pkg::ST_PREDICT: begin
            cmd.load_pred = 1'b1;
            cnt_in        = '0;
            state_in      = skf_pkg::ST_DIVIDE;
         end
         skf_pkg::ST_DIVIDE: begin
            cmd.div_step  = 1'b1;
            cmd.div_first = (cnt_ff == '0);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = skf_pkg::ST_CORR;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         skf_pkg::ST_CORR: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = skf_pkg::MUL_CORR;
            state_in    = skf_pkg::ST_VAR;
         end
         skf_pkg::ST_VAR: begin
            cmd.upd_estimate = 1'b1;
            cmd.mul_en       = 1'b1;
            cmd.mul_sel      = skf_pkg::MUL_VAR;
            state_in         = skf_pkg::ST_UPDATE;
         end
         skf_pkg::ST_UPDATE: begin
            cmd.upd_variance = 1'b1;
            state_in         = skf_pkg::ST_DONE;
         end
         skf_pkg::ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = skf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = skf_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

endmodule

FILE: rtl/core/skf_datapath.sv
`timescale 1ns / 1ps

module skf_datapath #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  skf_pkg::cmd_type      cmd,
   input  logic [DATA_WIDTH-1:0] req_measurement,
   input  logic                  csr_valid,
   input  logic [1:0]            csr_addr,
   input  logic [DATA_WIDTH-1:0] csr_wdata,
   output logic [DATA_WIDTH-1:0] rsp_filtered_value,
   output logic [DATA_WIDTH-1:0] rsp_error_variance
);

   localparam int DW = DATA_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int TS = skf_pkg::TS_BITS;
   // multiplier B operand covers gain (F+1 bits) and time step
   localparam int MB = (F + 1 > TS) ? F + 1 : TS;
   localparam int PW = DW + MB + 2;

   localparam longint unsigned ONE_L = 64'd1 << F;
   localparam logic [DW-1:0] PN_RST   = DW'((ONE_L + 64'd5) / 64'd10);  // 0.1
   localparam logic [DW-1:0] HALF_RST = DW'(ONE_L >> 1);                // 0.5
   localparam logic [DW-1:0] VAR_RST  = DW'(ONE_L);                     // 1.0
   localparam logic [F:0]    GAIN_ONE = {1'b1, {F{1'b0}}};

   // configuration and filter state
   logic [DW-1:0] pn_ff, mn_ff, vel_ff;
   logic [TS-1:0] ts_ff;
   logic [DW-1:0] estimate_ff, variance_ff;

   // per-transaction working registers
   logic [DW-1:0]        z_ff, xp_ff, pp_ff;
   logic [DW:0]          den_ff, rem_ff;
   logic [F:0]           quo_ff;
   logic signed [PW-1:0] prod_ff;
   logic [DW-1:0]        rsp_fv_ff, rsp_ev_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pn_ff  <= PN_RST;
         mn_ff  <= HALF_RST;
         vel_ff <= HALF_RST;
         ts_ff  <= skf_pkg::TS_RESET;
      end else if (csr_valid) begin
         unique case (skf_pkg::csr_index_type'(csr_addr))
            skf_pkg::CSR_PROCESS_NOISE:     pn_ff  <= csr_wdata;
            skf_pkg::CSR_MEASUREMENT_NOISE: mn_ff  <= csr_wdata;
            skf_pkg::CSR_VELOCITY:          vel_ff <= csr_wdata;
            skf_pkg::CSR_TIME_STEP:         ts_ff  <= csr_wdata[TS-1:0];
            default: ;
         endcase
      end
   end

   // Gain, zero when the denominator is zero
   logic [F:0] gain;
   assign gain = (den_ff == '0) ? '0 : quo_ff;

   // Innovation z - x_pred
   logic signed [DW:0] innov;
   assign innov = $signed({z_ff[DW-1], z_ff}) - $signed({xp_ff[DW-1], xp_ff});

   // Shared multiplier
   logic signed [DW:0]   mul_a;
   logic [MB-1:0]        mul_b;
   logic signed [PW-1:0] mul_p;

   always_comb begin
      unique case (cmd.mul_sel)
         skf_pkg::MUL_DRIFT: begin
            mul_a = $signed({vel_ff[DW-1], vel_ff});
            mul_b = MB'(ts_ff);
         end
         skf_pkg::MUL_CORR: begin
            mul_a = innov;
            mul_b = MB'(gain);
         end
         skf_pkg::MUL_VAR: begin
            mul_a = $signed({1'b0, pp_ff});
            mul_b = MB'(GAIN_ONE - gain);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * $signed({1'b0, mul_b});

   // Prediction: estimate + drift, variance + process noise
   logic [DW-1:0] drift;
   logic [DW:0]   x_sum, p_sum, s_sum;
   logic [DW-1:0] xp_c, pp_c;

   assign drift = prod_ff[TS +: DW];
   assign x_sum = {estimate_ff[DW-1], estimate_ff} + {drift[DW-1], drift};
   assign xp_c  = (x_sum[DW] != x_sum[DW-1]) ? {x_sum[DW], {(DW-1){~x_sum[DW]}}}
                                             : x_sum[DW-1:0];
   assign p_sum = {1'b0, variance_ff} + {1'b0, pn_ff};
   assign pp_c  = p_sum[DW] ? '1 : p_sum[DW-1:0];
   assign s_sum = {1'b0, pp_c} + {1'b0, mn_ff};

   // Restoring divider step: first step compares without doubling
   logic [DW+1:0] trial, trial_sub;
   logic          take;

   assign trial     = cmd.div_first ? {1'b0, rem_ff} : {rem_ff, 1'b0};
   assign take      = (trial >= {1'b0, den_ff});
   assign trial_sub = trial - {1'b0, den_ff};

   // Estimate update: x_pred + floor(innov * gain >> F), saturated
   logic [DW:0]   corr;
   logic [DW+1:0] xn_sum;
   logic [DW-1:0] xn_c;
   logic          xn_ovf;

   assign corr   = prod_ff[F +: DW+1];
   assign xn_sum = {{2{xp_ff[DW-1]}}, xp_ff} + {corr[DW], corr};
   assign xn_ovf = !((xn_sum[DW+1:DW-1] == 3'b000) || (xn_sum[DW+1:DW-1] == 3'b111));
   assign xn_c   = xn_ovf ? {xn_sum[DW+1], {(DW-1){~xn_sum[DW+1]}}} : xn_sum[DW-1:0];

   // Filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         estimate_ff <= '0;
         variance_ff <= VAR_RST;
      end else begin
         if (cmd.upd_estimate) begin
            estimate_ff <= xn_c;
         end
         // (1 - gain) * p_pred never exceeds p_pred, so no saturation
         if (cmd.upd_variance) begin
            variance_ff <= prod_ff[F +: DW];
         end
      end
   end

   // Working registers, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         z_ff <= req_measurement;
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_p;
      end
      if (cmd.load_pred) begin
         xp_ff  <= xp_c;
         pp_ff  <= pp_c;
         den_ff <= s_sum;
         rem_ff <= {1'b0, pp_c};
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= take ? trial_sub[DW:0] : trial[DW:0];
         quo_ff <= {quo_ff[F-1:0], take};
      end
      if (cmd.rsp_load) begin
         rsp_fv_ff <= estimate_ff;
         rsp_ev_ff <= variance_ff;
      end
   end

   assign rsp_filtered_value = rsp_fv_ff;
   assign rsp_error_variance = rsp_ev_ff;

endmodule

FILE: rtl/core/scalar_kalman_filter.sv
// rsp_valid rises once the DONE state has loaded the result into the output register.
// One transaction is processed at a time; the restoring gain divider, one quotient bit per
// cycle, is the longest phase of each transaction.
// A finished result waits in the output register while the next request is accepted.
// Reset (synchronous, active high) sets estimate 0, variance 1.0, and the registers to
// process_noise 0.1, measurement_noise 0.5, velocity 0.5, time_step 0.1.
`timescale 1ns / 1ps

module scalar_kalman_filter #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [DATA_WIDTH-1:0] req_measurement,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DATA_WIDTH-1:0] rsp_filtered_value,
   output logic [DATA_WIDTH-1:0] rsp_error_variance,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_addr,
   input  logic [DATA_WIDTH-1:0] csr_wdata
);

   skf_pkg::cmd_type cmd;

   // Registers are always writable
   assign csr_ready = 1'b1;

   skf_ctrl #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   skf_datapath #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_measurement    (req_measurement),
      .csr_valid          (csr_valid),
      .csr_addr           (csr_addr),
      .csr_wdata          (csr_wdata),
      .rsp_filtered_value (rsp_filtered_value),
      .rsp_error_variance (rsp_error_variance)
   );

   // One transaction in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while a transaction is in flight");

   // An accepted request starts with the drift product
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (cmd.mul_en && cmd.mul_sel == skf_pkg::MUL_DRIFT))
      else $error("drift multiply did not follow request");

   // Datapath phases never overlap
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.load_pred, cmd.div_step, cmd.upd_estimate,
                cmd.upd_variance, cmd.rsp_load}))
      else $error("overlapping datapath commands");

   // Loading the output register raises rsp_valid
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_valid)
      else $error("result loaded without rsp_valid");

endmodule
